// ----- design/ccb_pkg.sv -----
// Shared types and constants for the color box centroid block.
package ccb_pkg;

    localparam int PIX_W = 8;
    localparam int COORD_W = 12;
    localparam int QUOT_W = 12;
    localparam int COUNT_OUT_W = 25;
    localparam int CFG_ADDR_W = 3;
    localparam int MIN_HITS = 10;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RED_LOW    = 3'd0,
        REG_GREEN_LOW  = 3'd1,
        REG_BLUE_LOW   = 3'd2,
        REG_RED_HIGH   = 3'd3,
        REG_GREEN_HIGH = 3'd4,
        REG_BLUE_HIGH  = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- design/ccb_front.sv -----
// Pixel classification against the color box and per-frame accumulation.
module ccb_front
    import ccb_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    parameter int CNT_W = 25,
    parameter int SUM_W = 37
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [PIX_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_red,
    input  logic [PIX_W-1:0]      s_green,
    input  logic [PIX_W-1:0]      s_blue,
    input  logic [COORD_W-1:0]    s_col,
    input  logic [COORD_W-1:0]    s_row,
    input  logic                  s_frame_end,
    input  queue_status_t         q_status,
    output logic                  push,
    output logic [SUM_W-1:0]      push_col_sum,
    output logic [SUM_W-1:0]      push_row_sum,
    output logic [CNT_W-1:0]      push_count
);

    localparam int HIT_CAP = MAX_DIM * MAX_DIM;

    logic [PIX_W-1:0] red_low_reg, green_low_reg, blue_low_reg;
    logic [PIX_W-1:0] red_high_reg, green_high_reg, blue_high_reg;
    logic [SUM_W-1:0] col_sum_reg, col_sum_next;
    logic [SUM_W-1:0] row_sum_reg, row_sum_next;
    logic [CNT_W-1:0] hit_count_reg, hit_count_next;
    logic             accept;
    logic             hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_low_reg    <= '0;
            green_low_reg  <= '0;
            blue_low_reg   <= '0;
            red_high_reg   <= '0;
            green_high_reg <= '0;
            blue_high_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RED_LOW:    red_low_reg    <= cfg_wdata;
                REG_GREEN_LOW:  green_low_reg  <= cfg_wdata;
                REG_BLUE_LOW:   blue_low_reg   <= cfg_wdata;
                REG_RED_HIGH:   red_high_reg   <= cfg_wdata;
                REG_GREEN_HIGH: green_high_reg <= cfg_wdata;
                REG_BLUE_HIGH:  blue_high_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        hit = (s_red > red_low_reg) && (s_red < red_high_reg)
            && (s_green > green_low_reg) && (s_green < green_high_reg)
            && (s_blue > blue_low_reg) && (s_blue < blue_high_reg)
            && (hit_count_reg < CNT_W'(HIT_CAP));
        col_sum_next   = col_sum_reg;
        row_sum_next   = row_sum_reg;
        hit_count_next = hit_count_reg;
        if (hit) begin
            col_sum_next   = col_sum_reg + SUM_W'(s_col);
            row_sum_next   = row_sum_reg + SUM_W'(s_row);
            hit_count_next = hit_count_reg + CNT_W'(1);
        end
    end

    assign push         = accept && s_frame_end && (hit_count_next > CNT_W'(MIN_HITS));
    assign push_col_sum = col_sum_next;
    assign push_row_sum = row_sum_next;
    assign push_count   = hit_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_sum_reg   <= '0;
            row_sum_reg   <= '0;
            hit_count_reg <= '0;
        end else if (accept) begin
            if (s_frame_end) begin
                col_sum_reg   <= '0;
                row_sum_reg   <= '0;
                hit_count_reg <= '0;
            end else begin
                col_sum_reg   <= col_sum_next;
                row_sum_reg   <= row_sum_next;
                hit_count_reg <= hit_count_next;
            end
        end
    end

endmodule

// ----- design/ccb_queue.sv -----
// Short queue of frame totals between the accumulator and the divider.
module ccb_queue
    import ccb_pkg::*;
#(
    parameter int DATA_W = 99
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output queue_status_t     q_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    assign pop_data       = entry_reg[rd_ptr_reg];
    assign q_status.full  = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign q_status.empty = (fill_reg == '0);

endmodule

// ----- design/ccb_back.sv -----
// Restoring divider that turns frame totals into the centroid result.
module ccb_back
    import ccb_pkg::*;
#(
    parameter int CNT_W = 25,
    parameter int SUM_W = 37
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  queue_status_t          q_status,
    input  logic [SUM_W-1:0]       pop_col_sum,
    input  logic [SUM_W-1:0]       pop_row_sum,
    input  logic [CNT_W-1:0]       pop_count,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [QUOT_W-1:0]      m_center_col,
    output logic [QUOT_W-1:0]      m_center_row,
    output logic [COUNT_OUT_W-1:0] m_match_count
);

    localparam int DIV_W = CNT_W + QUOT_W - 1;
    localparam int STEP_W = $clog2(QUOT_W);

    back_state_t       state_reg, state_next;
    logic              div_en;
    logic [SUM_W-1:0]  col_rem_reg, col_rem_next;
    logic [SUM_W-1:0]  row_rem_reg, row_rem_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QUOT_W-1:0] col_quot_reg, col_quot_next;
    logic [QUOT_W-1:0] row_quot_reg, row_quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              col_ge, row_ge;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_status.empty) state_next = ST_DIV;
            ST_DIV:  if (step_reg == STEP_W'(QUOT_W - 1)) state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pop     = 1'b0;
        div_en  = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop = !q_status.empty;
            ST_DIV:  div_en = 1'b1;
            ST_OUT:  m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        col_ge        = col_rem_reg >= SUM_W'(div_reg);
        row_ge        = row_rem_reg >= SUM_W'(div_reg);
        col_rem_next  = col_rem_reg;
        row_rem_next  = row_rem_reg;
        div_next      = div_reg;
        cnt_next      = cnt_reg;
        col_quot_next = col_quot_reg;
        row_quot_next = row_quot_reg;
        step_next     = step_reg;
        if (pop) begin
            col_rem_next = pop_col_sum;
            row_rem_next = pop_row_sum;
            div_next     = DIV_W'(pop_count) << (QUOT_W - 1);
            cnt_next     = pop_count;
            step_next    = '0;
        end else if (div_en) begin
            if (col_ge) begin
                col_rem_next = col_rem_reg - SUM_W'(div_reg);
            end
            if (row_ge) begin
                row_rem_next = row_rem_reg - SUM_W'(div_reg);
            end
            col_quot_next = {col_quot_reg[QUOT_W-2:0], col_ge};
            row_quot_next = {row_quot_reg[QUOT_W-2:0], row_ge};
            div_next      = div_reg >> 1;
            step_next     = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        col_rem_reg  <= col_rem_next;
        row_rem_reg  <= row_rem_next;
        div_reg      <= div_next;
        cnt_reg      <= cnt_next;
        col_quot_reg <= col_quot_next;
        row_quot_reg <= row_quot_next;
        step_reg     <= step_next;
    end

    assign m_center_col  = col_quot_reg;
    assign m_center_row  = row_quot_reg;
    assign m_match_count = COUNT_OUT_W'(cnt_reg);

endmodule

// ----- design/color_box_centroid.sv -----
// Top level of the color box centroid block.
// The block takes one pixel word per clock while s_ready is high. Each channel
// is compared strictly against its lower and upper bound, and matching pixels
// add their column and row into running sums. On the word that carries
// frame_end the totals, including that last pixel, are handed to a two-entry
// queue when more than ten pixels matched, and the sums restart for the next
// frame. A restoring divider works out both means in parallel, one quotient
// bit per clock, and the result waits in the output register until taken.
// The input stalls only when both queue entries hold frames still waiting for
// the divider, which happens when results are not taken downstream or when
// frames with more than ten matches keep arriving faster than the divider
// finishes them.
module color_box_centroid
    import ccb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [PIX_W-1:0]       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PIX_W-1:0]       s_red,
    input  logic [PIX_W-1:0]       s_green,
    input  logic [PIX_W-1:0]       s_blue,
    input  logic [COORD_W-1:0]     s_col,
    input  logic [COORD_W-1:0]     s_row,
    input  logic                   s_frame_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [QUOT_W-1:0]      m_center_col,
    output logic [QUOT_W-1:0]      m_center_row,
    output logic [COUNT_OUT_W-1:0] m_match_count
);

    localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int SUM_W = CNT_W + COORD_W;
    localparam int ENTRY_W = 2 * SUM_W + CNT_W;

    queue_status_t     q_status;
    logic              push, pop;
    logic [SUM_W-1:0]  push_col_sum, push_row_sum;
    logic [CNT_W-1:0]  push_count;
    logic [ENTRY_W-1:0] pop_data;

    ccb_front #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W),
        .SUM_W   (SUM_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_col        (s_col),
        .s_row        (s_row),
        .s_frame_end  (s_frame_end),
        .q_status     (q_status),
        .push         (push),
        .push_col_sum (push_col_sum),
        .push_row_sum (push_row_sum),
        .push_count   (push_count)
    );

    ccb_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_col_sum, push_row_sum, push_count}),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    ccb_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .pop_col_sum   (pop_data[ENTRY_W-1 -: SUM_W]),
        .pop_row_sum   (pop_data[CNT_W +: SUM_W]),
        .pop_count     (pop_data[CNT_W-1:0]),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_center_col  (m_center_col),
        .m_center_row  (m_center_row),
        .m_match_count (m_match_count)
    );

endmodule

// ----- design/ccb_checker.sv -----
// Port-level checks for the color box centroid block and their binding.
module ccb_checker
    import ccb_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [QUOT_W-1:0]      m_center_col,
    input logic [QUOT_W-1:0]      m_center_row,
    input logic [COUNT_OUT_W-1:0] m_match_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_center_col)
            && $stable(m_center_row) && $stable(m_match_count))
        else $error("Result word changed while stalled.");

    a_min_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_match_count > COUNT_OUT_W'(MIN_HITS))
        else $error("Result word shows too few matching pixels.");

    a_gap_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("Result words appeared on consecutive cycles.");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("Block not idle after reset.");

endmodule

bind color_box_centroid ccb_checker u_ccb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_center_col  (m_center_col),
    .m_center_row  (m_center_row),
    .m_match_count (m_match_count)
);
